// ===== rtl/mcg_pkg.sv =====
// Shared types, constants and helper functions of the MIDI chord generator.
// Used by mcg_rbuf and midi_chord_generator; depends on nothing else.
package mcg_pkg;

  localparam int MAX_CHORD_NOTES = 32;
  localparam int HELD_DEPTH      = 12;
  localparam int MAX_OUT         = 64;

  localparam int CIDX_W  = $clog2(MAX_CHORD_NOTES);
  localparam int CCNT_W  = $clog2(MAX_CHORD_NOTES + 1);
  localparam int CADDR_W = $clog2(2 * MAX_CHORD_NOTES);
  localparam int HIDX_W  = $clog2(HELD_DEPTH);
  localparam int HCNT_W  = $clog2(HELD_DEPTH + 1);
  localparam int OIDX_W  = $clog2(MAX_OUT);
  localparam int OCNT_W  = $clog2(MAX_OUT + 1);

  localparam logic [6:0] MOD_LO  = 7'd60;
  localparam logic [6:0] MOD_HI  = 7'd71;
  localparam logic [6:0] TRIG_LO = 7'd72;
  localparam logic [6:0] TRIG_HI = 7'd83;
  localparam logic [6:0] VEL_MAX = 7'd127;

  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_CHORD_MODE = 3'd0,
    REG_LOW_LIMIT  = 3'd1,
    REG_HIGH_LIMIT = 3'd2,
    REG_RETRIGGER  = 3'd3,
    REG_SUPPRESS   = 3'd4
  } reg_e;

  typedef struct packed {
    logic       on;
    logic [4:0] ch;
    logic [6:0] note;
    logic [6:0] vel;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [OIDX_W-1:0] idx;
    res_t              data;
  } rwr_t;

  typedef struct packed {
    logic              start;
    logic [OCNT_W-1:0] count;
    logic              trunc;
  } rctl_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] bidx;
  } modk_t;

  // Remainder by twelve through a reciprocal multiply, exact for 8-bit inputs.
  function automatic logic [3:0] mod12(input logic [7:0] x);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(x) * 16'd171;
    q = p[15:11];
    r = x - 8'(q) * 8'd12;
    return r[3:0];
  endfunction

  // Modifier key (offset from note 60) to flag bit.
  function automatic modk_t mod_key(input logic [3:0] off);
    modk_t k;
    case (off)
      4'd0:    k = '{ok: 1'b1, bidx: 3'd4};
      4'd1:    k = '{ok: 1'b1, bidx: 3'd0};
      4'd2:    k = '{ok: 1'b1, bidx: 3'd5};
      4'd3:    k = '{ok: 1'b1, bidx: 3'd1};
      4'd5:    k = '{ok: 1'b1, bidx: 3'd6};
      4'd6:    k = '{ok: 1'b1, bidx: 3'd2};
      4'd7:    k = '{ok: 1'b1, bidx: 3'd7};
      4'd8:    k = '{ok: 1'b1, bidx: 3'd3};
      default: k = '{ok: 1'b0, bidx: 3'd0};
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/midi_chord_generator.sv =====
// MIDI chord generator top level: control sequencer, chord note store, APB registers.
// Depends on mcg_pkg and mcg_rbuf.
// Sequence: a plain pass-through runs DEC1, CLR, DEC2 and DRAIN; a chord step runs
//   the K kill reads, the walk over B range notes, the F note-offs and the N note-ons and
//   a commit before its results stream out, bounded by the one-port note memory walk.
// Throughput: one item at a time; the result buffer fetches the next result only after the
//   last one is taken, up to 64 results per item.
// Reset: registers return to chord_mode 1, limits 48..84, all counts zero, no root held;
//   no clearing pass, the note memory is only read below its counts.
module midi_chord_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [4:0] channel, [11:5] note_number, [18:12] velocity
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [4:0] out_channel, [11:5] out_note, [18:12] out_velocity
  output logic [1:0]  m_axis_tuser,   // [0] out_on, [1] truncated
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = mcg_pkg::CCNT_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'h001,
    S_DEC1   = 12'h002,
    S_CLR    = 12'h004,
    S_DEC2   = 12'h008,
    S_KILL   = 12'h010,
    S_BINIT  = 12'h020,
    S_BCLS   = 12'h040,
    S_BNOTE  = 12'h080,
    S_OFFS   = 12'h100,
    S_ONS    = 12'h200,
    S_COMMIT = 12'h400,
    S_DRAIN  = 12'h800
  } state_e;

  // Two banks of note memory: one holds the sounding chord, the other the chord
  // being built; commit swaps them.
  function automatic logic [mcg_pkg::CADDR_W-1:0] caddr(input logic bank,
                                                        input logic [mcg_pkg::CIDX_W-1:0] i);
    logic [mcg_pkg::CADDR_W-1:0] a;
    a = mcg_pkg::CADDR_W'(i);
    if (bank) a = a + mcg_pkg::CADDR_W'(mcg_pkg::MAX_CHORD_NOTES);
    return a;
  endfunction

  // ---------------- configuration registers ----------------
  logic       chord_mode_q, retrig_q, supp_q;
  logic [6:0] low_q, high_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_mode_q <= 1'b1;
      low_q        <= 7'd48;
      high_q       <= 7'd84;
      retrig_q     <= 1'b0;
      supp_q       <= 1'b0;
    end else if (cfg_we) begin
      case (mcg_pkg::reg_e'(paddr[4:2]))
        mcg_pkg::REG_CHORD_MODE: chord_mode_q <= pwdata[0];
        mcg_pkg::REG_LOW_LIMIT:  low_q        <= pwdata[6:0];
        mcg_pkg::REG_HIGH_LIMIT: high_q       <= pwdata[6:0];
        mcg_pkg::REG_RETRIGGER:  retrig_q     <= pwdata[0];
        mcg_pkg::REG_SUPPRESS:   supp_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (mcg_pkg::reg_e'(paddr[4:2]))
      mcg_pkg::REG_CHORD_MODE: prdata[0]   = chord_mode_q;
      mcg_pkg::REG_LOW_LIMIT:  prdata[6:0] = low_q;
      mcg_pkg::REG_HIGH_LIMIT: prdata[6:0] = high_q;
      mcg_pkg::REG_RETRIGGER:  prdata[0]   = retrig_q;
      mcg_pkg::REG_SUPPRESS:   prdata[0]   = supp_q;
      default:                 prdata      = '0;
    endcase
  end

  // ---------------- state ----------------
  state_e state_q, state_d;

  mcg_pkg::kind_e kind_q, kind_d;
  logic [4:0] ch_q, ch_d;
  logic [6:0] note_q, note_d, vel_q, vel_d;

  logic       prev_mode_q, prev_mode_d;
  logic [7:0] flags_q, flags_d;
  logic [6:0] held_q [mcg_pkg::HELD_DEPTH];
  logic [6:0] held_d [mcg_pkg::HELD_DEPTH];
  logic [mcg_pkg::HCNT_W-1:0] held_cnt_q, held_cnt_d;

  logic [CW-1:0] chord_cnt_q, chord_cnt_d, tgt_cnt_q, tgt_cnt_d, cur_n_q, cur_n_d;
  logic [6:0]    root_q, root_d;
  logic          root_v_q, root_v_d, bank_q, bank_d;
  logic [127:0]  cur_map_q, cur_map_d, tgt_map_q, tgt_map_d;
  logic [11:0]   pc_mask_q, pc_mask_d;
  logic [2:0]    cls_i_q, cls_i_d;
  logic [7:0]    cand_q, cand_d;
  logic          trunc_q, trunc_d;

  logic          do_kill_q, do_kill_d, do_play_q, do_play_d, smart_q, smart_d;
  logic          phase2_q, phase2_d;
  logic [4:0]    kill_ch_q, kill_ch_d;
  logic [6:0]    kill_vel_q, kill_vel_d, play_root_q, play_root_d, play_vel_q, play_vel_d;

  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d, drn_q, drn_d;
  logic [mcg_pkg::OCNT_W-1:0] nres_q, nres_d;

  // note memory
  logic [6:0] cmem [2 * mcg_pkg::MAX_CHORD_NOTES];
  logic [6:0] cm_rdata_q;
  logic       cm_we, rd_en;
  logic [mcg_pkg::CADDR_W-1:0] cm_waddr, rd_addr;
  logic [6:0] cm_wdata;

  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    if (rd_en) begin
      cm_rdata_q <= cmem[rd_addr];
    end
  end

  // ---------------- held stack removal ----------------
  logic [mcg_pkg::HELD_DEPTH-1:0] hit;
  logic       found, seen;
  logic [6:0] held_rm [mcg_pkg::HELD_DEPTH];
  logic [mcg_pkg::HCNT_W-1:0] cnt_rm, held_top_i, rm_top_i;
  logic [6:0] held_top, rm_top;

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < mcg_pkg::HELD_DEPTH; i++) begin
      hit[i] = (mcg_pkg::HCNT_W'(i) < held_cnt_q) && (held_q[i] == note_q);
    end
    found = |hit;
    for (int i = 0; i < mcg_pkg::HELD_DEPTH; i++) begin
      seen = seen | hit[i];
      if (seen && (i < mcg_pkg::HELD_DEPTH - 1)) held_rm[i] = held_q[i+1];
      else                                       held_rm[i] = held_q[i];
    end
    cnt_rm     = held_cnt_q - mcg_pkg::HCNT_W'(found);
    held_top_i = held_cnt_q - 1'b1;
    rm_top_i   = cnt_rm - 1'b1;
    held_top   = held_q[held_top_i[mcg_pkg::HIDX_W-1:0]];
    rm_top     = held_rm[rm_top_i[mcg_pkg::HIDX_W-1:0]];
  end

  // ---------------- chord pitch classes ----------------
  logic [3:0] cls_w [5];
  logic [2:0] ncls_w;
  logic [3:0] t1, t2, e1, e2;
  logic       tr;
  logic [1:0] ne;
  logic [3:0] off_w [4];

  always_comb begin
    tr = |flags_q[3:0];
    t1 = 4'd0;
    t2 = 4'd0;
    if      (flags_q[0]) begin t1 = 4'd3; t2 = 4'd6; end
    else if (flags_q[1]) begin t1 = 4'd3; t2 = 4'd7; end
    else if (flags_q[2]) begin t1 = 4'd4; t2 = 4'd7; end
    else if (flags_q[3]) begin t1 = 4'd2; t2 = 4'd7; end
    e1 = 4'd0;
    e2 = 4'd0;
    ne = 2'd0;
    if      (flags_q[4]) begin e1 = 4'd9;  ne = 2'd1; end
    else if (flags_q[5]) begin e1 = 4'd10; ne = 2'd1; end
    else if (flags_q[6]) begin e1 = 4'd11; ne = 2'd1; end
    else if (flags_q[7]) begin e1 = 4'd10; e2 = 4'd14; ne = 2'd2; end
    if (tr) begin
      off_w[0] = t1; off_w[1] = t2; off_w[2] = e1; off_w[3] = e2;
    end else begin
      off_w[0] = e1; off_w[1] = e2; off_w[2] = 4'd0; off_w[3] = 4'd0;
    end
    ncls_w   = 3'd1 + (tr ? 3'd2 : 3'd0) + 3'(ne);
    cls_w[0] = mcg_pkg::mod12({1'b0, play_root_q});
    for (int i = 0; i < 4; i++) begin
      cls_w[i+1] = mcg_pkg::mod12({1'b0, play_root_q} + 8'(off_w[i]));
    end
  end

  // ---------------- sequencer ----------------
  mcg_pkg::rwr_t  rwr;
  mcg_pkg::rctl_t rctl;
  mcg_pkg::res_t  emit_r, rb_data;
  mcg_pkg::modk_t key;
  logic           emit_v, rbusy, rb_valid, rb_trunc, rb_last;
  logic           on_w, accept, issue, loop_done, loop_bank;
  logic [CW-1:0]  loop_n;
  logic [3:0]     pc, lm;
  logic [4:0]     dd;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign on_w          = (kind_q == mcg_pkg::KIND_ON);
  assign key           = mcg_pkg::mod_key(4'(note_q - mcg_pkg::MOD_LO));

  always_comb begin
    loop_n    = '0;
    loop_bank = bank_q;
    unique case (state_q)
      S_KILL:  loop_n = chord_cnt_q;
      S_OFFS:  loop_n = cur_n_q;
      S_ONS:   begin loop_n = tgt_cnt_q; loop_bank = !bank_q; end
      default: loop_n = '0;
    endcase
    issue     = (iss_q < loop_n);
    loop_done = !issue && !pend_q;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    ch_d        = ch_q;
    note_d      = note_q;
    vel_d       = vel_q;
    prev_mode_d = prev_mode_q;
    flags_d     = flags_q;
    held_d      = held_q;
    held_cnt_d  = held_cnt_q;
    chord_cnt_d = chord_cnt_q;
    tgt_cnt_d   = tgt_cnt_q;
    cur_n_d     = cur_n_q;
    root_d      = root_q;
    root_v_d    = root_v_q;
    bank_d      = bank_q;
    cur_map_d   = cur_map_q;
    tgt_map_d   = tgt_map_q;
    pc_mask_d   = pc_mask_q;
    cls_i_d     = cls_i_q;
    cand_d      = cand_q;
    trunc_d     = trunc_q;
    do_kill_d   = do_kill_q;
    do_play_d   = do_play_q;
    smart_d     = smart_q;
    phase2_d    = phase2_q;
    kill_ch_d   = kill_ch_q;
    kill_vel_d  = kill_vel_q;
    play_root_d = play_root_q;
    play_vel_d  = play_vel_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    drn_d       = drn_q;
    nres_d      = nres_q;
    emit_v      = 1'b0;
    emit_r      = '0;
    cm_we       = 1'b0;
    cm_waddr    = '0;
    cm_wdata    = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rctl        = '0;
    pc          = '0;
    lm          = '0;
    dd          = '0;

    // memory walk shared by the kill, note-off and note-on passes
    if ((state_q == S_KILL) || (state_q == S_OFFS) || (state_q == S_ONS)) begin
      if (issue) begin
        rd_en   = 1'b1;
        rd_addr = caddr(loop_bank, iss_q[mcg_pkg::CIDX_W-1:0]);
        iss_d   = iss_q + 1'b1;
      end
      pend_d = issue;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = mcg_pkg::kind_e'(s_axis_tuser);
          ch_d    = s_axis_tdata[4:0];
          note_d  = s_axis_tdata[11:5];
          vel_d   = s_axis_tdata[18:12];
          nres_d  = '0;
          trunc_d = 1'b0;
          if (mcg_pkg::kind_e'(s_axis_tuser) != mcg_pkg::KIND_NONE) state_d = S_DEC1;
        end
      end
      S_DEC1: begin
        // range change re-voices the held top note
        if ((kind_q == mcg_pkg::KIND_RANGE) && (held_cnt_q != '0)) begin
          play_root_d = held_top;
          play_vel_d  = mcg_pkg::VEL_MAX;
          smart_d     = !retrig_q;
          phase2_d    = 1'b0;
          state_d     = S_BINIT;
        end else begin
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        // drop the stored chord silently when chord mode comes back on
        if (chord_mode_q && !prev_mode_q) begin
          chord_cnt_d = '0;
          root_v_d    = 1'b0;
          cur_map_d   = '0;
        end
        prev_mode_d = chord_mode_q;
        state_d     = S_DEC2;
      end
      S_DEC2: begin
        phase2_d  = 1'b1;
        do_kill_d = 1'b0;
        do_play_d = 1'b0;
        state_d   = S_DRAIN;
        if (kind_q == mcg_pkg::KIND_RANGE) begin
          state_d = S_DRAIN;
        end else if (!chord_mode_q) begin
          emit_v = 1'b1;
          emit_r = '{on: on_w, ch: ch_q, note: note_q, vel: vel_q};
        end else if ((note_q >= mcg_pkg::MOD_LO) && (note_q <= mcg_pkg::MOD_HI)) begin
          if (key.ok && (flags_q[key.bidx] != on_w)) begin
            flags_d[key.bidx] = on_w;
            if (held_cnt_q != '0) begin
              do_kill_d   = 1'b1;
              kill_ch_d   = ch_q;
              kill_vel_d  = '0;
              do_play_d   = 1'b1;
              play_root_d = held_top;
              play_vel_d  = mcg_pkg::VEL_MAX;
              smart_d     = 1'b0;
              state_d     = S_KILL;
            end
          end
        end else if ((note_q >= mcg_pkg::TRIG_LO) && (note_q <= mcg_pkg::TRIG_HI) && on_w) begin
          held_d     = held_rm;
          held_cnt_d = cnt_rm;
          if (cnt_rm < mcg_pkg::HCNT_W'(mcg_pkg::HELD_DEPTH)) begin
            held_d[cnt_rm[mcg_pkg::HIDX_W-1:0]] = note_q;
            held_cnt_d = cnt_rm + 1'b1;
          end
          do_kill_d   = 1'b1;
          kill_ch_d   = ch_q;
          kill_vel_d  = '0;
          do_play_d   = 1'b1;
          play_root_d = note_q;
          play_vel_d  = vel_q;
          smart_d     = 1'b0;
          state_d     = S_KILL;
        end else if ((note_q >= mcg_pkg::TRIG_LO) && (note_q <= mcg_pkg::TRIG_HI)) begin
          held_d     = held_rm;
          held_cnt_d = cnt_rm;
          if (root_v_q && (root_q == note_q)) begin
            do_kill_d   = 1'b1;
            kill_ch_d   = ch_q;
            kill_vel_d  = vel_q;
            do_play_d   = (cnt_rm != '0);
            play_root_d = rm_top;
            play_vel_d  = mcg_pkg::VEL_MAX;
            smart_d     = 1'b0;
            state_d     = S_KILL;
          end else begin
            emit_v = 1'b1;
            emit_r = '{on: 1'b0, ch: ch_q, note: note_q, vel: vel_q};
          end
        end else begin
          emit_v = 1'b1;
          emit_r = '{on: on_w, ch: ch_q, note: note_q, vel: vel_q};
        end
        iss_d = '0;
      end
      S_KILL: begin
        if (pend_q) begin
          emit_v = 1'b1;
          emit_r = '{on: 1'b0, ch: kill_ch_q, note: cm_rdata_q, vel: kill_vel_q};
        end
        if (loop_done) begin
          chord_cnt_d = '0;
          root_v_d    = 1'b0;
          cur_map_d   = '0;
          state_d     = do_play_q ? S_BINIT : S_DRAIN;
        end
      end
      S_BINIT: begin
        tgt_cnt_d = '0;
        tgt_map_d = '0;
        pc_mask_d = '0;
        cls_i_d   = '0;
        state_d   = S_BCLS;
      end
      S_BCLS: begin
        if (cls_i_q == ncls_w) begin
          cur_n_d = (root_v_q && (root_q == play_root_q)) ? chord_cnt_q : '0;
          iss_d   = '0;
          state_d = S_OFFS;
        end else begin
          pc = cls_w[cls_i_q];
          if (pc_mask_q[pc]) begin
            // pitch class already walked: all its notes are duplicates
            cls_i_d = cls_i_q + 1'b1;
          end else begin
            pc_mask_d[pc] = 1'b1;
            lm = mcg_pkg::mod12({1'b0, low_q});
            dd = {1'b0, pc} + 5'd12 - {1'b0, lm};
            if (dd >= 5'd12) dd = dd - 5'd12;
            cand_d  = {1'b0, low_q} + 8'(dd);
            state_d = S_BNOTE;
          end
        end
      end
      S_BNOTE: begin
        if (cand_q <= {1'b0, high_q}) begin
          if (tgt_cnt_q < CW'(mcg_pkg::MAX_CHORD_NOTES)) begin
            cm_we     = 1'b1;
            cm_waddr  = caddr(!bank_q, tgt_cnt_q[mcg_pkg::CIDX_W-1:0]);
            cm_wdata  = cand_q[6:0];
            tgt_map_d[cand_q[6:0]] = 1'b1;
            tgt_cnt_d = tgt_cnt_q + 1'b1;
          end else begin
            trunc_d = 1'b1;
          end
          cand_d = cand_q + 8'd12;
        end else begin
          cls_i_d = cls_i_q + 1'b1;
          state_d = S_BCLS;
        end
      end
      S_OFFS: begin
        if (pend_q && (!smart_q || !tgt_map_q[cm_rdata_q])) begin
          emit_v = 1'b1;
          emit_r = '{on: 1'b0, ch: 5'd1, note: cm_rdata_q, vel: 7'd0};
        end
        if (loop_done) begin
          iss_d   = '0;
          state_d = supp_q ? S_COMMIT : S_ONS;
        end
      end
      S_ONS: begin
        if (pend_q && (!smart_q || !((cur_n_q != '0) && cur_map_q[cm_rdata_q]))) begin
          emit_v = 1'b1;
          emit_r = '{on: 1'b1, ch: 5'd1, note: cm_rdata_q, vel: play_vel_q};
        end
        if (loop_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // swap banks: the built chord becomes the sounding chord
        bank_d      = !bank_q;
        chord_cnt_d = tgt_cnt_q;
        cur_map_d   = tgt_map_q;
        root_d      = play_root_q;
        root_v_d    = 1'b1;
        state_d     = phase2_q ? S_DRAIN : S_CLR;
      end
      S_DRAIN: begin
        if (!drn_q) begin
          if (nres_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rctl  = '{start: 1'b1, count: nres_q, trunc: trunc_q};
            drn_d = 1'b1;
          end
        end else if (!rbusy) begin
          drn_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // results beyond the buffer depth are dropped
    rwr = '0;
    if (emit_v && (nres_q < mcg_pkg::OCNT_W'(mcg_pkg::MAX_OUT))) begin
      rwr    = '{en: 1'b1, idx: nres_q[mcg_pkg::OIDX_W-1:0], data: emit_r};
      nres_d = nres_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= mcg_pkg::KIND_ON;
      ch_q        <= '0;
      note_q      <= '0;
      vel_q       <= '0;
      prev_mode_q <= 1'b1;
      flags_q     <= '0;
      held_cnt_q  <= '0;
      chord_cnt_q <= '0;
      tgt_cnt_q   <= '0;
      cur_n_q     <= '0;
      root_q      <= '0;
      root_v_q    <= 1'b0;
      bank_q      <= 1'b0;
      cur_map_q   <= '0;
      tgt_map_q   <= '0;
      pc_mask_q   <= '0;
      cls_i_q     <= '0;
      cand_q      <= '0;
      trunc_q     <= 1'b0;
      do_kill_q   <= 1'b0;
      do_play_q   <= 1'b0;
      smart_q     <= 1'b0;
      phase2_q    <= 1'b0;
      kill_ch_q   <= '0;
      kill_vel_q  <= '0;
      play_root_q <= '0;
      play_vel_q  <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      drn_q       <= 1'b0;
      nres_q      <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      ch_q        <= ch_d;
      note_q      <= note_d;
      vel_q       <= vel_d;
      prev_mode_q <= prev_mode_d;
      flags_q     <= flags_d;
      held_cnt_q  <= held_cnt_d;
      chord_cnt_q <= chord_cnt_d;
      tgt_cnt_q   <= tgt_cnt_d;
      cur_n_q     <= cur_n_d;
      root_q      <= root_d;
      root_v_q    <= root_v_d;
      bank_q      <= bank_d;
      cur_map_q   <= cur_map_d;
      tgt_map_q   <= tgt_map_d;
      pc_mask_q   <= pc_mask_d;
      cls_i_q     <= cls_i_d;
      cand_q      <= cand_d;
      trunc_q     <= trunc_d;
      do_kill_q   <= do_kill_d;
      do_play_q   <= do_play_d;
      smart_q     <= smart_d;
      phase2_q    <= phase2_d;
      kill_ch_q   <= kill_ch_d;
      kill_vel_q  <= kill_vel_d;
      play_root_q <= play_root_d;
      play_vel_q  <= play_vel_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      drn_q       <= drn_d;
      nres_q      <= nres_d;
    end
  end

  // held stack entries carry no reset: only entries below the count are read
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // ---------------- result buffer ----------------
  mcg_rbuf u_rbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rwr),
    .ctl_i     (rctl),
    .busy_o    (rbusy),
    .m_valid_o (rb_valid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (rb_data),
    .m_trunc_o (rb_trunc),
    .m_last_o  (rb_last)
  );

  assign m_axis_tvalid = rb_valid;
  assign m_axis_tdata  = {5'b0, rb_data.vel, rb_data.note, rb_data.ch};
  assign m_axis_tuser  = {rb_trunc, rb_data.on};
  assign m_axis_tlast  = rb_last;

  // ---------------- assertions ----------------
  a_nres_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= mcg_pkg::OCNT_W'(mcg_pkg::MAX_OUT))
    else $error("result count beyond buffer depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input accepted while results still pending");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chord_cnt_q <= CW'(mcg_pkg::MAX_CHORD_NOTES)) &&
    (held_cnt_q <= mcg_pkg::HCNT_W'(mcg_pkg::HELD_DEPTH)))
    else $error("store count out of range");

  a_commit_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> root_v_q)
    else $error("commit left no sounding root");

endmodule

// ===== rtl/mcg_rbuf.sv =====
// Result buffer: collects the results of one input item, then streams them out.
// Depends on mcg_pkg.
module mcg_rbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mcg_pkg::rwr_t wr_i,
  input  mcg_pkg::rctl_t ctl_i,
  output logic          busy_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output mcg_pkg::res_t m_data_o,
  output logic          m_trunc_o,
  output logic          m_last_o
);

  mcg_pkg::res_t mem [mcg_pkg::MAX_OUT];
  mcg_pkg::res_t rdata_q;

  logic                       busy_q, fetch_q, out_v_q, last_q, trunc_q;
  logic [mcg_pkg::OCNT_W-1:0] rd_idx_q, cnt_q;
  logic                       rd_en;

  assign rd_en = busy_q && !fetch_q && !out_v_q && (rd_idx_q < cnt_q);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[mcg_pkg::OIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      fetch_q  <= 1'b0;
      out_v_q  <= 1'b0;
      last_q   <= 1'b0;
      trunc_q  <= 1'b0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      fetch_q <= rd_en;
      if (ctl_i.start) begin
        busy_q   <= 1'b1;
        cnt_q    <= ctl_i.count;
        trunc_q  <= ctl_i.trunc;
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (fetch_q) begin
        out_v_q <= 1'b1;
        last_q  <= (rd_idx_q == cnt_q);
      end else if (out_v_q && m_ready_i) begin
        out_v_q <= 1'b0;
        if (last_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o    = busy_q;
  assign m_valid_o = out_v_q;
  assign m_data_o  = rdata_q;
  assign m_trunc_o = trunc_q;
  assign m_last_o  = last_q;

endmodule
